### hdl/cbpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbpq_pkg;

   // Queue geometry.
   localparam int WINDOW       = 7;
   localparam int BUCKET_DEPTH = 256;
   localparam int NUM_BUCKETS  = WINDOW + 1;

   // Field widths.
   localparam int COST_W   = 16;
   localparam int ROW_W    = 32;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int ENTRY_W  = ROW_W + 3 * BYTE_W;

   // Derived widths.
   localparam int CUR_W    = COST_W + 1;
   localparam int BUCKET_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int IDX_W    = $clog2(BUCKET_DEPTH + 1);
   localparam int OFS_W    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
   localparam int ADDR_W   = $clog2(NUM_BUCKETS * BUCKET_DEPTH);

   // Request operations.
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_GRAB   = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] RSP_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] RSP_RETURNED = 3'd1;
   localparam logic [STATUS_W-1:0] RSP_NO_WORK  = 3'd2;
   localparam logic [STATUS_W-1:0] RSP_OUTSIDE  = 3'd3;
   localparam logic [STATUS_W-1:0] RSP_FULL     = 3'd4;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;      // capture the accepted request
      logic insert_go;  // commit an insert and load the response
      logic grab_go;    // finish a grab and load the response
      logic advance;    // step the current cost past an empty bucket
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_grab;
      logic scan_exhausted;
      logic scan_hit;
   } dp_stat_type;

endpackage

`default_nettype wire

### hdl/cbpq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cbpq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire cbpq_pkg::dp_stat_type stat,
   output cbpq_pkg::dp_cmd_type     cmd
);
   import cbpq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      finish;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      finish    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!stat.is_grab) begin
               if (out_free) begin
                  cmd.insert_go = 1'b1;
                  finish        = 1'b1;
               end
            end else if (stat.scan_exhausted || stat.scan_hit) begin
               if (out_free) begin
                  cmd.grab_go = 1'b1;
                  finish      = 1'b1;
               end
            end else begin
               cmd.advance = 1'b1;
            end
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

`default_nettype wire

### hdl/cbpq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module cbpq_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire cbpq_pkg::dp_cmd_type           cmd,
   output cbpq_pkg::dp_stat_type               stat,
   input  wire logic                           req_cmd,
   input  wire logic [cbpq_pkg::COST_W-1:0]    req_cost,
   input  wire logic [cbpq_pkg::ROW_W-1:0]     req_row_id,
   input  wire logic [cbpq_pkg::BYTE_W-1:0]    req_bit_value,
   input  wire logic [cbpq_pkg::BYTE_W-1:0]    req_lane_number,
   input  wire logic [cbpq_pkg::BYTE_W-1:0]    req_step_delta,
   input  wire logic                           csr_write,
   input  wire logic [cbpq_pkg::COST_W-1:0]    csr_cost_limit,
   output logic      [cbpq_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [cbpq_pkg::COST_W-1:0]    rsp_entry_cost,
   output logic      [cbpq_pkg::ROW_W-1:0]     rsp_entry_row_id,
   output logic      [cbpq_pkg::BYTE_W-1:0]    rsp_entry_bit_value,
   output logic      [cbpq_pkg::BYTE_W-1:0]    rsp_entry_lane,
   output logic      [cbpq_pkg::BYTE_W-1:0]    rsp_entry_delta
);
   import cbpq_pkg::*;

   // Captured request.
   logic                cmd_ff;
   logic [COST_W-1:0]   cost_ff;
   logic [ENTRY_W-1:0]  entry_ff;

   // Queue state.
   logic [COST_W-1:0]   bucket_cost_ff  [NUM_BUCKETS];
   logic [IDX_W-1:0]    bucket_rd_ff    [NUM_BUCKETS];
   logic [IDX_W-1:0]    bucket_wr_ff    [NUM_BUCKETS];
   logic [CUR_W-1:0]    cur_ff;
   logic [BUCKET_W-1:0] cur_bucket_ff;
   logic [COST_W-1:0]   hc_ff;
   logic                hc_valid_ff;
   logic [COST_W-1:0]   limit_ff;

   // Entry memory and its registered read port.
   logic [ENTRY_W-1:0]  mem [NUM_BUCKETS * BUCKET_DEPTH];
   logic [ENTRY_W-1:0]  mem_q_ff;

   // Response register.
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COST_W-1:0]   rsp_cost_ff, rsp_cost_in;

   logic [CUR_W-1:0]    diff;
   logic [CUR_W:0]      win_top;
   logic                in_window;
   logic [BUCKET_W:0]   ins_sum;
   logic [BUCKET_W-1:0] ins_bucket;
   logic [BUCKET_W-1:0] sel_bucket;
   logic [IDX_W-1:0]    sel_rd, sel_wr, eff_wr;
   logic [COST_W-1:0]   sel_cost;
   logic                empty, full;
   logic                exhausted, hit, over_limit;
   logic [ADDR_W-1:0]   base, addr;
   logic                mem_we, mem_re;
   logic [STATUS_W-1:0] ins_status, grab_status;

   always_comb begin
      diff      = CUR_W'(cost_ff) - cur_ff;
      win_top   = (CUR_W+1)'(cur_ff) + (CUR_W+1)'(WINDOW);
      in_window = ((cost_ff == '0) && (cur_ff == '0)) ||
                  ((CUR_W'(cost_ff) > cur_ff) && ((CUR_W+1)'(cost_ff) <= win_top));
      // The offset from the current cost is at most WINDOW, so one wrap suffices.
      ins_sum = {1'b0, cur_bucket_ff} + {1'b0, diff[BUCKET_W-1:0]};
      if (ins_sum >= (BUCKET_W+1)'(NUM_BUCKETS)) begin
         ins_sum = ins_sum - (BUCKET_W+1)'(NUM_BUCKETS);
      end
      ins_bucket = ins_sum[BUCKET_W-1:0];

      sel_bucket = (cmd_ff == CMD_GRAB) ? cur_bucket_ff : ins_bucket;
      sel_rd     = bucket_rd_ff[sel_bucket];
      sel_wr     = bucket_wr_ff[sel_bucket];
      sel_cost   = bucket_cost_ff[sel_bucket];

      empty  = (sel_rd == sel_wr);
      eff_wr = empty ? '0 : sel_wr;
      full   = (eff_wr >= IDX_W'(BUCKET_DEPTH));

      exhausted  = !hc_valid_ff || (cur_ff > CUR_W'(hc_ff));
      hit        = !exhausted && (sel_rd < sel_wr);
      over_limit = (cur_ff > CUR_W'(limit_ff));

      if (!in_window) begin
         ins_status = RSP_OUTSIDE;
      end else if (full) begin
         ins_status = RSP_FULL;
      end else begin
         ins_status = RSP_INSERTED;
      end
      grab_status = (exhausted || over_limit) ? RSP_NO_WORK : RSP_RETURNED;

      base = ADDR_W'(sel_bucket) * ADDR_W'(BUCKET_DEPTH);
      if (cmd_ff == CMD_GRAB) begin
         addr = base + ADDR_W'(sel_rd[OFS_W-1:0]);
      end else begin
         addr = base + ADDR_W'(eff_wr[OFS_W-1:0]);
      end
      mem_we = cmd.insert_go && (ins_status == RSP_INSERTED);
      mem_re = cmd.grab_go && (grab_status == RSP_RETURNED);

      rsp_status_in = rsp_status_ff;
      rsp_cost_in   = rsp_cost_ff;
      if (cmd.insert_go) begin
         rsp_status_in = ins_status;
         rsp_cost_in   = '0;
      end else if (cmd.grab_go) begin
         rsp_status_in = grab_status;
         rsp_cost_in   = (grab_status == RSP_RETURNED) ? sel_cost : '0;
      end

      stat.is_grab        = (cmd_ff == CMD_GRAB);
      stat.scan_exhausted = exhausted;
      stat.scan_hit       = hit;
   end

   // The opcode and cost are reset so the bucket lookup is defined before the
   // first request arrives; the payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff  <= CMD_INSERT;
         cost_ff <= '0;
      end else if (cmd.latch) begin
         cmd_ff   <= req_cmd;
         cost_ff  <= req_cost;
         entry_ff <= {req_row_id, req_bit_value, req_lane_number, req_step_delta};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            bucket_cost_ff[i] <= '0;
            bucket_rd_ff[i]   <= '0;
            bucket_wr_ff[i]   <= '0;
         end
         cur_ff        <= '0;
         cur_bucket_ff <= '0;
         hc_ff         <= '0;
         hc_valid_ff   <= 1'b0;
         limit_ff      <= '1;
         rsp_status_ff <= RSP_INSERTED;
         rsp_cost_ff   <= '0;
      end else begin
         rsp_status_ff <= rsp_status_in;
         rsp_cost_ff   <= rsp_cost_in;
         if (csr_write) begin
            limit_ff <= csr_cost_limit;
         end
         if (mem_we) begin
            if (empty) begin
               bucket_cost_ff[sel_bucket] <= cost_ff;
               bucket_rd_ff[sel_bucket]   <= '0;
            end
            bucket_wr_ff[sel_bucket] <= eff_wr + IDX_W'(1);
            if (!hc_valid_ff || (cost_ff > hc_ff)) begin
               hc_ff       <= cost_ff;
               hc_valid_ff <= 1'b1;
            end
         end
         if (mem_re) begin
            bucket_rd_ff[sel_bucket] <= sel_rd + IDX_W'(1);
         end
         if (cmd.advance) begin
            cur_ff <= cur_ff + CUR_W'(1);
            if (cur_bucket_ff == BUCKET_W'(NUM_BUCKETS - 1)) begin
               cur_bucket_ff <= '0;
            end else begin
               cur_bucket_ff <= cur_bucket_ff + BUCKET_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr] <= entry_ff;
      end
      if (mem_re) begin
         mem_q_ff <= mem[addr];
      end
   end

   // Payload fields come from the read register, which holds until the next grab that returns an entry.
   always_comb begin
      rsp_status     = rsp_status_ff;
      rsp_entry_cost = rsp_cost_ff;
      if (rsp_status_ff == RSP_RETURNED) begin
         {rsp_entry_row_id, rsp_entry_bit_value, rsp_entry_lane, rsp_entry_delta} = mem_q_ff;
      end else begin
         {rsp_entry_row_id, rsp_entry_bit_value, rsp_entry_lane, rsp_entry_delta} = '0;
      end
   end

   a_rd_not_past_wr: assert property (@(posedge clock) disable iff (reset)
      sel_rd <= sel_wr)
      else $error("bucket read index passed its write index");

   a_wr_in_range: assert property (@(posedge clock) disable iff (reset)
      sel_wr <= IDX_W'(BUCKET_DEPTH))
      else $error("bucket write index beyond bucket depth");

   a_cur_bucket_range: assert property (@(posedge clock) disable iff (reset)
      cur_bucket_ff <= BUCKET_W'(NUM_BUCKETS - 1))
      else $error("current bucket pointer out of range");

   a_advance_only_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> (!exhausted && !hit))
      else $error("scan advanced past a live bucket");

   a_grab_read_moves_rd: assert property (@(posedge clock) disable iff (reset)
      mem_re |=> (rsp_status_ff == RSP_RETURNED))
      else $error("entry read without a returned status");

endmodule

`default_nettype wire

### hdl/cyclic_bucket_priority_queue_top.sv
// Monotone bucket priority queue.
// Requests arrive on the req_ channel (valid/ready). A request with req_cmd
// clear inserts an entry of cost req_cost with its payload; with req_cmd set
// it grabs the oldest entry of the lowest live cost. Every request yields
// exactly one response on the rsp_ channel (valid/ready) with a status code
// and, for a returned entry, its cost and payload; other fields read zero.
// The cost limit is written on the csr_ channel, which is always ready.
// One request is in work at a time. A grab first steps the current-cost
// pointer over empty buckets, with a single bucket lookup per cycle. The
// entry memory has one port, used at most once per request. A response sits
// in an output register, so the next request is accepted while it waits;
// when the receiver stalls, the following request holds in its final step
// until the output register frees. Synchronous reset empties all buckets,
// clears the current cost, marks no cost as seen and restores the cost limit
// to its maximum. The entry memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module cyclic_bucket_priority_queue_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_cmd,
   input  wire logic [cbpq_pkg::COST_W-1:0]    req_cost,
   input  wire logic [cbpq_pkg::ROW_W-1:0]     req_row_id,
   input  wire logic [cbpq_pkg::BYTE_W-1:0]    req_bit_value,
   input  wire logic [cbpq_pkg::BYTE_W-1:0]    req_lane_number,
   input  wire logic [cbpq_pkg::BYTE_W-1:0]    req_step_delta,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [cbpq_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [cbpq_pkg::COST_W-1:0]    rsp_entry_cost,
   output logic      [cbpq_pkg::ROW_W-1:0]     rsp_entry_row_id,
   output logic      [cbpq_pkg::BYTE_W-1:0]    rsp_entry_bit_value,
   output logic      [cbpq_pkg::BYTE_W-1:0]    rsp_entry_lane,
   output logic      [cbpq_pkg::BYTE_W-1:0]    rsp_entry_delta,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [cbpq_pkg::COST_W-1:0]    csr_cost_limit
);
   import cbpq_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // The configuration register takes a write in any cycle.
   assign csr_ready = 1'b1;

   // The controller sequences each request and owns both handshakes.
   cbpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   // The datapath holds the bucket ring, the entry memory and the response.
   cbpq_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (dp_cmd),
      .stat                (dp_stat),
      .req_cmd             (req_cmd),
      .req_cost            (req_cost),
      .req_row_id          (req_row_id),
      .req_bit_value       (req_bit_value),
      .req_lane_number     (req_lane_number),
      .req_step_delta      (req_step_delta),
      .csr_write           (csr_valid && csr_ready),
      .csr_cost_limit      (csr_cost_limit),
      .rsp_status          (rsp_status),
      .rsp_entry_cost      (rsp_entry_cost),
      .rsp_entry_row_id    (rsp_entry_row_id),
      .rsp_entry_bit_value (rsp_entry_bit_value),
      .rsp_entry_lane      (rsp_entry_lane),
      .rsp_entry_delta     (rsp_entry_delta)
   );

endmodule

`default_nettype wire

### dv/cyclic_bucket_priority_queue_top_test.sv
`timescale 1ns / 1ps

module cyclic_bucket_priority_queue_top_test;
   import cbpq_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int HOLD_OFF       = 80;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic              cmd;
      logic [COST_W-1:0] cost;
      logic [ROW_W-1:0]  row_id;
      logic [BYTE_W-1:0] bit_value;
      logic [BYTE_W-1:0] lane_number;
      logic [BYTE_W-1:0] step_delta;
   } request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COST_W-1:0]   cost;
      logic [ROW_W-1:0]    row_id;
      logic [BYTE_W-1:0]   bit_value;
      logic [BYTE_W-1:0]   lane;
      logic [BYTE_W-1:0]   delta;
   } response_type;

   typedef struct packed {
      logic [ROW_W-1:0]  row_id;
      logic [BYTE_W-1:0] bit_value;
      logic [BYTE_W-1:0] lane;
      logic [BYTE_W-1:0] delta;
   } slot_type;

   // A directed row either carries its response typed in, or leaves it to the
   // queue mirror below.
   typedef struct packed {
      logic         typed;
      request_type  req;
      response_type rsp;
   } directed_row_type;

   localparam response_type PREDICTED    = '0;
   localparam response_type EXP_INSERTED = '{RSP_INSERTED, 16'd0, 32'd0, 8'd0, 8'd0, 8'd0};
   localparam response_type EXP_OUTSIDE  = '{RSP_OUTSIDE, 16'd0, 32'd0, 8'd0, 8'd0, 8'd0};
   localparam response_type EXP_NO_WORK  = '{RSP_NO_WORK, 16'd0, 32'd0, 8'd0, 8'd0, 8'd0};

   localparam int DIRECTED_COUNT = 23;
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // Nothing has been inserted yet, so a grab finds no work.
      '{1'b1, '{CMD_GRAB,   16'd0,     32'h0000_0000, 8'h00, 8'h00, 8'h00}, EXP_NO_WORK},
      '{1'b1, '{CMD_INSERT, 16'd1,     32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF}, EXP_INSERTED},
      // Cost zero is legal only while the current cost is still zero.
      '{1'b1, '{CMD_INSERT, 16'd0,     32'h0000_0000, 8'h00, 8'h00, 8'h00}, EXP_INSERTED},
      // One past the window, and the largest cost, are both rejected.
      '{1'b1, '{CMD_INSERT, 16'd8,     32'h1234_5678, 8'h12, 8'h34, 8'h56}, EXP_OUTSIDE},
      '{1'b1, '{CMD_INSERT, 16'd65535, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF}, EXP_OUTSIDE},
      '{1'b1, '{CMD_INSERT, 16'd7,     32'hA5A5_5A5A, 8'h3C, 8'hC3, 8'h81}, EXP_INSERTED},
      '{1'b1, '{CMD_GRAB,   16'd0,     32'h0000_0000, 8'h00, 8'h00, 8'h00},
              '{RSP_RETURNED, 16'd0, 32'h0000_0000, 8'h00, 8'h00, 8'h00}},
      '{1'b1, '{CMD_GRAB,   16'd0,     32'h0000_0000, 8'h00, 8'h00, 8'h00},
              '{RSP_RETURNED, 16'd1, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF}},
      // The current cost has moved to one: zero and one itself are now out.
      '{1'b1, '{CMD_INSERT, 16'd0,     32'h0000_0001, 8'h01, 8'h01, 8'h01}, EXP_OUTSIDE},
      '{1'b1, '{CMD_INSERT, 16'd1,     32'h0000_0002, 8'h02, 8'h02, 8'h02}, EXP_OUTSIDE},
      // Top of the window lands in the bucket that cost zero emptied.
      '{1'b1, '{CMD_INSERT, 16'd8,     32'h0000_0008, 8'h08, 8'h08, 8'h08}, EXP_INSERTED},
      '{1'b0, '{CMD_INSERT, 16'd8,     32'h8000_0001, 8'h80, 8'h01, 8'h7F}, PREDICTED},
      // The scan steps over several empty buckets before it hits cost 7.
      '{1'b0, '{CMD_GRAB,   16'hFFFF,  32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF}, PREDICTED},
      '{1'b0, '{CMD_GRAB,   16'd0,     32'h0000_0000, 8'h00, 8'h00, 8'h00}, PREDICTED},
      '{1'b0, '{CMD_GRAB,   16'd0,     32'h0000_0000, 8'h00, 8'h00, 8'h00}, PREDICTED},
      // Everything is drained, and the current cost runs past the highest.
      '{1'b1, '{CMD_GRAB,   16'd0,     32'h0000_0000, 8'h00, 8'h00, 8'h00}, EXP_NO_WORK},
      '{1'b1, '{CMD_INSERT, 16'd9,     32'h0000_0009, 8'h09, 8'h09, 8'h09}, EXP_OUTSIDE},
      '{1'b0, '{CMD_INSERT, 16'd16,    32'h0F0F_F0F0, 8'h55, 8'hAA, 8'h01}, PREDICTED},
      '{1'b0, '{CMD_INSERT, 16'd10,    32'h7FFF_FFFE, 8'hFE, 8'h7F, 8'h80}, PREDICTED},
      '{1'b0, '{CMD_GRAB,   16'd0,     32'h0000_0000, 8'h00, 8'h00, 8'h00}, PREDICTED},
      '{1'b0, '{CMD_GRAB,   16'd0,     32'h0000_0000, 8'h00, 8'h00, 8'h00}, PREDICTED},
      '{1'b1, '{CMD_GRAB,   16'd0,     32'h0000_0000, 8'h00, 8'h00, 8'h00}, EXP_NO_WORK},
      '{1'b1, '{CMD_GRAB,   16'hFFFF,  32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF}, EXP_NO_WORK}
   };

   // Clock, reset and every block input start at a known value.
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_cmd = CMD_INSERT;
   logic [COST_W-1:0]   req_cost = '0;
   logic [ROW_W-1:0]    req_row_id = '0;
   logic [BYTE_W-1:0]   req_bit_value = '0;
   logic [BYTE_W-1:0]   req_lane_number = '0;
   logic [BYTE_W-1:0]   req_step_delta = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [COST_W-1:0]   rsp_entry_cost;
   logic [ROW_W-1:0]    rsp_entry_row_id;
   logic [BYTE_W-1:0]   rsp_entry_bit_value;
   logic [BYTE_W-1:0]   rsp_entry_lane;
   logic [BYTE_W-1:0]   rsp_entry_delta;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [COST_W-1:0]   csr_cost_limit = '0;

   // Mirror of the queue: bucket ring, pointers, current and highest cost.
   slot_type          slots [NUM_BUCKETS*BUCKET_DEPTH];
   int                bucket_tag [NUM_BUCKETS];
   int                head_ptr [NUM_BUCKETS];
   int                tail_ptr [NUM_BUCKETS];
   int                live_cost = 0;
   int                top_cost = -1;
   logic [COST_W-1:0] cost_ceiling = 16'hFFFF;

   // Responses still owed by the block, oldest first.
   response_type due_responses [$];

   bit quiet = 1'b0;           // both sides skip their random idling
   int hold_off_cycles = 0;    // one long receiver stall, taken by the sink
   int requests_sent = 0;
   int responses_seen = 0;
   int limit_writes = 0;
   int mismatch_count = 0;
   int status_count [5] = '{default: 0};

   cyclic_bucket_priority_queue_top u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_cost            (req_cost),
      .req_row_id          (req_row_id),
      .req_bit_value       (req_bit_value),
      .req_lane_number     (req_lane_number),
      .req_step_delta      (req_step_delta),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_entry_cost      (rsp_entry_cost),
      .rsp_entry_row_id    (rsp_entry_row_id),
      .rsp_entry_bit_value (rsp_entry_bit_value),
      .rsp_entry_lane      (rsp_entry_lane),
      .rsp_entry_delta     (rsp_entry_delta),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_cost_limit      (csr_cost_limit)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Applies one accepted request to the mirror and returns the response it
   // must produce. An insert lands in bucket cost mod (WINDOW+1); a grab
   // walks the current cost forward over empty buckets, at most to one past the
   // highest cost seen, and then either hands out the oldest entry or
   // reports that no work is left.
   function automatic response_type bucket_queue_step(input request_type req);
      response_type res;
      int           c;
      int           b;
      res = '0;
      if (req.cmd == CMD_INSERT) begin
         c = int'(req.cost);
         if (!((c == 0 && live_cost == 0) || (c > live_cost && c <= live_cost + WINDOW))) begin
            res.status = RSP_OUTSIDE;
         end else begin
            b = c % NUM_BUCKETS;
            // An empty bucket is re-tagged with the new cost and restarts.
            if (head_ptr[b] == tail_ptr[b]) begin
               bucket_tag[b] = c;
               head_ptr[b] = 0;
               tail_ptr[b] = 0;
            end
            if (tail_ptr[b] >= BUCKET_DEPTH) begin
               res.status = RSP_FULL;
            end else begin
               slots[b*BUCKET_DEPTH + tail_ptr[b]] =
                  '{req.row_id, req.bit_value, req.lane_number, req.step_delta};
               tail_ptr[b]++;
               if (c > top_cost) top_cost = c;
               res.status = RSP_INSERTED;
            end
         end
      end else begin
         b = 0;
         while (live_cost <= top_cost) begin
            b = live_cost % NUM_BUCKETS;
            if (head_ptr[b] < tail_ptr[b]) break;
            live_cost++;
         end
         if (live_cost > int'(cost_ceiling) || live_cost > top_cost) begin
            res.status = RSP_NO_WORK;
         end else begin
            res.status    = RSP_RETURNED;
            res.cost      = bucket_tag[b][COST_W-1:0];
            res.row_id    = slots[b*BUCKET_DEPTH + head_ptr[b]].row_id;
            res.bit_value = slots[b*BUCKET_DEPTH + head_ptr[b]].bit_value;
            res.lane      = slots[b*BUCKET_DEPTH + head_ptr[b]].lane;
            res.delta     = slots[b*BUCKET_DEPTH + head_ptr[b]].delta;
            head_ptr[b]++;
         end
      end
      return res;
   endfunction

   // Random request shaped around the current cost: most inserts fall inside
   // the live window, a few are near misses or fully random costs. Payloads
   // are always random, grabs included, since the block must ignore them.
   function automatic request_type draw_request(input int grab_pct);
      request_type req;
      int          roll;
      req.cmd         = CMD_INSERT;
      req.cost        = COST_W'($urandom);
      req.row_id      = ROW_W'($urandom);
      req.bit_value   = BYTE_W'($urandom);
      req.lane_number = BYTE_W'($urandom);
      req.step_delta  = BYTE_W'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < grab_pct) begin
         req.cmd = CMD_GRAB;
      end else if (roll < grab_pct + 8) begin
         case ($urandom_range(0, 3))
            0: req.cost = COST_W'(live_cost);
            1: req.cost = COST_W'(live_cost + WINDOW + 1);
            2: req.cost = '0;
            default: ;
         endcase
      end else if (live_cost == 0 && $urandom_range(0, 3) == 0) begin
         req.cost = '0;
      end else begin
         req.cost = COST_W'(live_cost + int'($urandom_range(1, WINDOW)));
      end
      return req;
   endfunction

   // Presents one request, holding valid and payload until it is taken. The
   // response is predicted at the very edge that accepts the request, so the
   // mirror always advances in acceptance order. Entered and left at a
   // falling edge; valid is left high in case the next request follows at once.
   task automatic offer_request(input request_type req, input logic typed,
                                input response_type typed_rsp);
      int           gap;
      response_type predicted;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_cmd         = req.cmd;
      req_cost        = req.cost;
      req_row_id      = req.row_id;
      req_bit_value   = req.bit_value;
      req_lane_number = req.lane_number;
      req_step_delta  = req.step_delta;
      req_valid       = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = bucket_queue_step(req);
      due_responses.push_back(typed ? typed_rsp : predicted);
      requests_sent++;
      @(negedge clock);
   endtask

   // Every request yields a response, so once none is owed the block is idle.
   task automatic wait_drained();
      while (due_responses.size() != 0) @(negedge clock);
   endtask

   task automatic write_cost_limit(input logic [COST_W-1:0] value);
      csr_cost_limit = value;
      csr_valid      = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cost_ceiling = value;
      limit_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic run_mixed(input int count, input int grab_pct);
      for (int i = 0; i < count; i++) begin
         // Now and then a stretch runs with no idling on either side.
         if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
         offer_request(draw_request(grab_pct), 1'b0, PREDICTED);
      end
      quiet = 1'b0;
   endtask

   // Piles more inserts of one cost than a bucket holds, so the tail of the
   // burst is turned away as full. The receiver is told to stall for a long
   // stretch at the same time, so the block also backs up and drops ready.
   task automatic fill_one_bucket();
      request_type       req;
      logic [COST_W-1:0] burst_cost;
      burst_cost = COST_W'(live_cost + int'($urandom_range(1, WINDOW)));
      hold_off_cycles = HOLD_OFF;
      for (int i = 0; i < BUCKET_DEPTH + 6; i++) begin
         req = draw_request(0);
         req.cmd = CMD_INSERT;
         req.cost = burst_cost;
         offer_request(req, 1'b0, PREDICTED);
      end
   endtask

   // Response sink: draws a stall per response, honors the one long hold-off
   // request, and checks each accepted response against the oldest one owed.
   initial begin : response_sink
      int           gap;
      response_type actual;
      response_type wanted;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_off_cycles != 0) begin
            rsp_ready = 1'b0;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
         end
         gap = quiet ? 0 : $urandom_range(0, 3);
         if (gap != 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         actual = '{rsp_status, rsp_entry_cost, rsp_entry_row_id, rsp_entry_bit_value,
                    rsp_entry_lane, rsp_entry_delta};
         responses_seen++;
         if (actual.status < 5) status_count[actual.status]++;
         if (due_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("response %0d arrived with none outstanding: status %0d cost %0d",
                        responses_seen, actual.status, actual.cost);
         end else begin
            wanted = due_responses.pop_front();
            if (actual !== wanted) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("response %0d wrong: expected status %0d cost %0d row %h %h %h %h",
                           responses_seen, wanted.status, wanted.cost, wanted.row_id,
                           wanted.bit_value, wanted.lane, wanted.delta);
                  $display("                    actual   status %0d cost %0d row %h %h %h %h",
                           actual.status, actual.cost, actual.row_id,
                           actual.bit_value, actual.lane, actual.delta);
               end
            end
         end
         @(negedge clock);
      end
   end

   // Ends a hung run: too many cycles in a row with no handshake on any port.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      wait (!reset);
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      int leftover;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
         bucket_tag[b] = 0;
         head_ptr[b]   = 0;
         tail_ptr[b]   = 0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part under the reset cost limit.
      for (int i = 0; i < DIRECTED_COUNT; i++)
         offer_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].rsp);
      req_valid = 1'b0;
      wait_drained();

      // Limit of zero: once the current cost is above it every grab finds no work.
      write_cost_limit('0);
      run_mixed(80, 45);
      req_valid = 1'b0;
      wait_drained();

      write_cost_limit(16'hFFFF);
      run_mixed(350, 45);
      req_valid = 1'b0;
      wait_drained();

      // A limit a little ahead of the current cost, so grabs run into it.
      write_cost_limit(COST_W'(live_cost + int'($urandom_range(0, 24))));
      run_mixed(200, 45);
      req_valid = 1'b0;
      wait_drained();

      // Open the limit again, overfill one bucket, then drain with heavy grabs.
      write_cost_limit(16'hFFFF);
      fill_one_bucket();
      run_mixed(200, 70);
      req_valid = 1'b0;
      wait_drained();

      repeat (SETTLE_CYCLES) @(negedge clock);
      leftover = due_responses.size();
      if (leftover != 0) begin
         mismatch_count += leftover;
         $display("%0d responses never arrived", leftover);
      end

      $display("Sent %0d requests: %0d inserted, %0d returned, %0d no work,",
               requests_sent, status_count[RSP_INSERTED], status_count[RSP_RETURNED],
               status_count[RSP_NO_WORK]);
      $display("%0d outside, %0d full; cost limit written %0d times (max, zero, near the",
               status_count[RSP_OUTSIDE], status_count[RSP_FULL], limit_writes);
      $display("current cost); %0d errors.", mismatch_count);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
